// ===== rtl/core/hcbp_pkg.sv =====
// hcbp_pkg: shared constants, command codes and control types of the
// huffman code bit packer; no dependencies
`default_nettype none

package hcbp_pkg;

  localparam int MAX_CODE_LEN_DEF = 24;
  localparam int SYMBOL_COUNT_DEF = 128;

  localparam int SYMBOL_W    = 7;
  localparam int CMD_W       = 2;
  localparam int CODE_LEN_W  = 5;
  localparam int CODE_BITS_W = 24;
  localparam int BYTE_W      = 8;

  localparam logic [SYMBOL_W-1:0] END_SYMBOL_RST = 7'h1A;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD   = 2'd0,
    CMD_ENCODE = 2'd1,
    CMD_END    = 2'd2
  } cmd_e;

  // packer datapath controls from the sequencer
  typedef struct packed {
    logic append;
    logic emit;
    logic clear;
  } pack_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/hcbp_if.sv =====
// hcbp_if: valid/ready channel interfaces for input commands and packed bytes
// depends on hcbp_pkg
`default_nettype none

interface hcbp_in_if
  import hcbp_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic [CMD_W-1:0]       command;
  logic [SYMBOL_W-1:0]    symbol;
  logic [CODE_LEN_W-1:0]  code_length;
  logic [CODE_BITS_W-1:0] code_bits;

  modport source (output valid, command, symbol, code_length, code_bits, input ready);
  modport sink   (input valid, command, symbol, code_length, code_bits, output ready);
endinterface

interface hcbp_out_if
  import hcbp_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              last_byte;
  logic              error;

  modport source (output valid, out_byte, last_byte, error, input ready);
  modport sink   (input valid, out_byte, last_byte, error, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/hcbp_code_table.sv =====
// hcbp_code_table: code length and codeword memory with per-entry valid bits
// depends on hcbp_pkg
`default_nettype none

module hcbp_code_table
  import hcbp_pkg::*;
#(
  parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF,
  parameter int SYMBOL_COUNT = SYMBOL_COUNT_DEF,
  localparam int LEN_W = $clog2(MAX_CODE_LEN + 1),
  localparam int CB_W  = (MAX_CODE_LEN < CODE_BITS_W) ? MAX_CODE_LEN : CODE_BITS_W
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   we_i,
  input  wire logic [SYMBOL_W-1:0]    waddr_i,
  input  wire logic [CODE_LEN_W-1:0]  wlen_i,
  input  wire logic [CODE_BITS_W-1:0] wbits_i,
  input  wire logic                   re_i,
  input  wire logic [SYMBOL_W-1:0]    raddr_i,
  output logic                        hit_o,
  output logic [LEN_W-1:0]            len_o,
  output logic [CB_W-1:0]             bits_o
);

  localparam int IDX_W   = $clog2(SYMBOL_COUNT);
  localparam int EXT_W   = SYMBOL_W + 2;
  localparam int ENTRY_W = LEN_W + CB_W;

  logic [ENTRY_W-1:0]      mem_q [SYMBOL_COUNT];
  logic [SYMBOL_COUNT-1:0] valid_q;
  logic [ENTRY_W-1:0]      rd_q;
  logic                    hit_q;

  logic [EXT_W-1:0]       waddr_ext, raddr_ext;
  logic                   w_in_range, r_in_range;
  logic [IDX_W-1:0]       widx, ridx;
  logic [LEN_W-1:0]       sat_len;
  logic [CODE_BITS_W-1:0] len_mask, masked_bits;

  assign waddr_ext  = {2'b00, waddr_i};
  assign raddr_ext  = {2'b00, raddr_i};
  assign w_in_range = waddr_ext < EXT_W'(SYMBOL_COUNT);
  assign r_in_range = raddr_ext < EXT_W'(SYMBOL_COUNT);
  assign widx       = waddr_ext[IDX_W-1:0];
  assign ridx       = raddr_ext[IDX_W-1:0];

  always_comb begin
    if (32'(wlen_i) > MAX_CODE_LEN) begin
      sat_len = LEN_W'(MAX_CODE_LEN);
    end else begin
      sat_len = LEN_W'(wlen_i);
    end
  end

  // drop codeword bits above the stored length
  assign len_mask    = ~({CODE_BITS_W{1'b1}} << sat_len);
  assign masked_bits = wbits_i & len_mask;

  always_ff @(posedge clk_i) begin
    if (we_i && w_in_range) begin
      mem_q[widx] <= {sat_len, masked_bits[CB_W-1:0]};
    end
    if (re_i) begin
      rd_q <= mem_q[ridx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      hit_q   <= 1'b0;
    end else begin
      if (we_i && w_in_range) begin
        valid_q[widx] <= 1'b1;
      end
      if (re_i) begin
        hit_q <= r_in_range && valid_q[ridx];
      end
    end
  end

  // an entry never written reads as length zero
  assign hit_o  = hit_q;
  assign len_o  = hit_q ? rd_q[ENTRY_W-1 -: LEN_W] : '0;
  assign bits_o = rd_q[CB_W-1:0];

endmodule

`default_nettype wire

// ===== rtl/core/hcbp_packer.sv =====
// hcbp_packer: msb-aligned bit accumulator with an alignment shifter for appended codes
// depends on hcbp_pkg
`default_nettype none

module hcbp_packer
  import hcbp_pkg::*;
#(
  parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF,
  localparam int LEN_W  = $clog2(MAX_CODE_LEN + 1),
  localparam int CB_W   = (MAX_CODE_LEN < CODE_BITS_W) ? MAX_CODE_LEN : CODE_BITS_W,
  localparam int ACC_W  = MAX_CODE_LEN + BYTE_W,
  localparam int PEND_W = $clog2(ACC_W + 1)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire pack_ctl_t         ctl_i,
  input  wire logic [LEN_W-1:0]  len_i,
  input  wire logic [CB_W-1:0]   bits_i,
  output logic [BYTE_W-1:0]      top_byte_o,
  output logic [PEND_W-1:0]      pending_o
);

  logic [ACC_W-1:0]  acc_q, acc_d;
  logic [PEND_W-1:0] pend_q, pend_d;
  logic [PEND_W-1:0] shamt;
  logic [ACC_W-1:0]  code_ext;

  // new code lands right below the bits already held
  assign shamt    = PEND_W'(ACC_W) - pend_q - PEND_W'(len_i);
  assign code_ext = {{(ACC_W - CB_W){1'b0}}, bits_i};

  always_comb begin
    acc_d  = acc_q;
    pend_d = pend_q;
    if (ctl_i.clear) begin
      acc_d  = '0;
      pend_d = '0;
    end else if (ctl_i.append) begin
      acc_d  = acc_q | (code_ext << shamt);
      pend_d = pend_q + PEND_W'(len_i);
    end else if (ctl_i.emit) begin
      acc_d  = acc_q << BYTE_W;
      pend_d = (pend_q >= PEND_W'(BYTE_W)) ? pend_q - PEND_W'(BYTE_W) : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      pend_q <= '0;
    end else begin
      acc_q  <= acc_d;
      pend_q <= pend_d;
    end
  end

  assign top_byte_o = acc_q[ACC_W-1 -: BYTE_W];
  assign pending_o  = pend_q;

endmodule

`default_nettype wire

// ===== rtl/core/huffman_code_bit_packer.sv =====
// huffman_code_bit_packer: load writes the table; encode and end read it,
// then emit bytes, end also flushing any zero-padded last byte; an absent or zero-length
// code gives an error byte. a registered table read, then one byte a cycle through the
// output register while it is free. one item at a time. async active-low reset clears
// table valid bits and packer, sets end_symbol to 26; no clearing pass is needed.
// depends on hcbp_pkg, hcbp_if, hcbp_code_table, hcbp_packer
`default_nettype none

module huffman_code_bit_packer
  import hcbp_pkg::*;
#(
  parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF,
  parameter int SYMBOL_COUNT = SYMBOL_COUNT_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [SYMBOL_W-1:0] cfg_wdata_i,
  hcbp_in_if.sink                  in_i,
  hcbp_out_if.source               out_o
);

  localparam int LEN_W  = $clog2(MAX_CODE_LEN + 1);
  localparam int CB_W   = (MAX_CODE_LEN < CODE_BITS_W) ? MAX_CODE_LEN : CODE_BITS_W;
  localparam int ACC_W  = MAX_CODE_LEN + BYTE_W;
  localparam int PEND_W = $clog2(ACC_W + 1);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_LOOKUP = 4'b0010,
    ST_EMIT   = 4'b0100,
    ST_ERR    = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic [SYMBOL_W-1:0] end_symbol_q;
  logic is_end_q, is_end_d;

  logic              out_valid_q, out_valid_d;
  logic [BYTE_W-1:0] out_byte_q, out_byte_d;
  logic              out_last_q, out_last_d;
  logic              out_err_q, out_err_d;

  logic              accept, tab_we, tab_re, out_free, load;
  logic [SYMBOL_W-1:0] raddr;
  logic              hit;
  logic [LEN_W-1:0]  rd_len;
  logic [CB_W-1:0]   rd_bits;
  logic [BYTE_W-1:0] top_byte;
  logic [PEND_W-1:0] pending;
  pack_ctl_t         ctl;

  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;

  always_comb begin
    tab_we   = 1'b0;
    tab_re   = 1'b0;
    is_end_d = is_end_q;
    unique case (cmd_e'(in_i.command))
      CMD_LOAD:   tab_we = accept;
      CMD_ENCODE: begin
        tab_re   = accept;
        is_end_d = accept ? 1'b0 : is_end_q;
      end
      CMD_END: begin
        tab_re   = accept;
        is_end_d = accept ? 1'b1 : is_end_q;
      end
      default: ;
    endcase
  end

  assign raddr = (cmd_e'(in_i.command) == CMD_END) ? end_symbol_q : in_i.symbol;

  hcbp_code_table #(
    .MAX_CODE_LEN (MAX_CODE_LEN),
    .SYMBOL_COUNT (SYMBOL_COUNT)
  ) u_table (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (tab_we),
    .waddr_i (in_i.symbol),
    .wlen_i  (in_i.code_length),
    .wbits_i (in_i.code_bits),
    .re_i    (tab_re),
    .raddr_i (raddr),
    .hit_o   (hit),
    .len_o   (rd_len),
    .bits_o  (rd_bits)
  );

  hcbp_packer #(
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_packer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .len_i      (rd_len),
    .bits_i     (rd_bits),
    .top_byte_o (top_byte),
    .pending_o  (pending)
  );

  always_comb begin
    state_d     = state_q;
    ctl         = '0;
    load        = 1'b0;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    out_err_d   = out_err_q;
    unique case (state_q)
      ST_IDLE: begin
        if (tab_re) begin
          state_d = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (!hit || rd_len == '0) begin
          state_d = ST_ERR;
        end else begin
          ctl.append = 1'b1;
          state_d    = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (pending >= PEND_W'(BYTE_W)) begin
          if (out_free) begin
            load       = 1'b1;
            out_byte_d = top_byte;
            out_err_d  = 1'b0;
            out_last_d = is_end_q && (pending == PEND_W'(BYTE_W));
            ctl.emit   = 1'b1;
            if (is_end_q && (pending == PEND_W'(BYTE_W))) begin
              ctl.clear = 1'b1;
              state_d   = ST_IDLE;
            end
          end
        end else if (is_end_q && pending != '0) begin
          // zero-padded final partial byte
          if (out_free) begin
            load       = 1'b1;
            out_byte_d = top_byte;
            out_err_d  = 1'b0;
            out_last_d = 1'b1;
            ctl.clear  = 1'b1;
            state_d    = ST_IDLE;
          end
        end else begin
          ctl.clear = is_end_q;
          state_d   = ST_IDLE;
        end
      end
      ST_ERR: begin
        if (out_free) begin
          load       = 1'b1;
          out_byte_d = '0;
          out_last_d = is_end_q;
          out_err_d  = 1'b1;
          ctl.clear  = is_end_q;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      end_symbol_q <= END_SYMBOL_RST;
      is_end_q     <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      is_end_q    <= is_end_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        end_symbol_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
    out_err_q  <= out_err_d;
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.out_byte  = out_byte_q;
  assign out_o.last_byte = out_last_q;
  assign out_o.error     = out_err_q;

endmodule

`default_nettype wire
